// ===== rtl/u8v_pkg.sv =====
`default_nettype none

package u8v_pkg;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_LEAD     = 2'd1,
    ERR_CONT     = 2'd2,
    ERR_OVERLONG = 2'd3
  } u8v_err_e;

  // Pending test on the first continuation byte of a 3- or 4-byte form
  typedef enum logic [1:0] {
    CHK_NONE = 2'd0,
    CHK_3B   = 2'd1,
    CHK_4B   = 2'd2
  } u8v_chk_e;

  typedef struct packed {
    logic [1:0] cont_left;
    u8v_chk_e   second_chk;
    logic       overlong;
    u8v_err_e   first_err;
  } u8v_state_t;

  localparam u8v_state_t STATE_RESET = '{
    cont_left:  2'd0,
    second_chk: CHK_NONE,
    overlong:   1'b0,
    first_err:  ERR_NONE
  };

  typedef struct packed {
    logic     valid_res;
    u8v_err_e error_kind;
  } u8v_result_t;

endpackage

`default_nettype wire

// ===== rtl/u8v_if.sv =====
`default_nettype none

interface u8v_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface u8v_res_if;
  logic       valid;
  logic       ready;
  logic       valid_res;
  logic [1:0] error_kind;

  modport source (output valid, output valid_res, output error_kind, input ready);
  modport sink   (input valid, input valid_res, input error_kind, output ready);
endinterface

`default_nettype wire

// ===== rtl/u8v_step.sv =====
`default_nettype none

module u8v_step (
  input  u8v_pkg::u8v_state_t  state_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_byte_i,
  output u8v_pkg::u8v_state_t  state_o,
  output u8v_pkg::u8v_result_t result_o
);

  u8v_pkg::u8v_state_t nxt;
  logic [1:0]          cnt_dec;
  logic                ov;

  always_comb begin
    nxt     = state_i;
    cnt_dec = state_i.cont_left - 2'd1;
    ov      = state_i.overlong;

    if (state_i.first_err == u8v_pkg::ERR_NONE) begin
      if (state_i.cont_left != 2'd0) begin
        if (data_byte_i[7:6] != 2'b10) begin
          nxt            = u8v_pkg::STATE_RESET;
          nxt.first_err  = u8v_pkg::ERR_CONT;
        end else begin
          if (state_i.second_chk == u8v_pkg::CHK_3B && !data_byte_i[5]) begin
            ov = 1'b1;
          end
          if (state_i.second_chk == u8v_pkg::CHK_4B && data_byte_i[5:4] == 2'b00) begin
            ov = 1'b1;
          end
          nxt.second_chk = u8v_pkg::CHK_NONE;
          nxt.cont_left  = cnt_dec;
          nxt.overlong   = ov;
          // report overlong only once the sequence is complete
          if (cnt_dec == 2'd0 && ov) begin
            nxt           = u8v_pkg::STATE_RESET;
            nxt.first_err = u8v_pkg::ERR_OVERLONG;
          end
        end
      end else begin
        if (!data_byte_i[7]) begin
          nxt = state_i;
        end else if (data_byte_i[7:5] == 3'b110) begin
          nxt.cont_left = 2'd1;
          nxt.overlong  = (data_byte_i[4:1] == 4'd0);
        end else if (data_byte_i[7:4] == 4'b1110) begin
          nxt.cont_left  = 2'd2;
          nxt.second_chk = (data_byte_i[3:0] == 4'd0) ? u8v_pkg::CHK_3B : u8v_pkg::CHK_NONE;
        end else if (data_byte_i[7:3] == 5'b11110) begin
          nxt.cont_left  = 2'd3;
          nxt.second_chk = (data_byte_i[2:0] == 3'd0) ? u8v_pkg::CHK_4B : u8v_pkg::CHK_NONE;
        end else begin
          nxt.first_err = u8v_pkg::ERR_LEAD;
        end
      end
    end

    // truncated sequence at the end of the string
    if (last_byte_i && nxt.first_err == u8v_pkg::ERR_NONE && nxt.cont_left != 2'd0) begin
      nxt.first_err = u8v_pkg::ERR_CONT;
    end

    result_o.valid_res  = (nxt.first_err == u8v_pkg::ERR_NONE);
    result_o.error_kind = nxt.first_err;

    state_o = last_byte_i ? u8v_pkg::STATE_RESET : nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/utf8_stream_validator_core.sv =====
// UTF-8 stream checker, one byte per transfer.
// byte_i carries data_byte and last_byte; a string is any run of bytes
// closed by a transfer with last_byte set. res_o carries one result per
// string: valid_res and error_kind (none, bad lead, bad or missing
// continuation, overlong), the first error of the string.
// Throughput: one byte per cycle, sustained, while res_o is not stalled.
// A closing byte is taken into the input register stage and decoded there;
// its result is registered in the output stage, visible from then on.
// Bytes that do not close a string give no result and never wait on res_o.
// A stalled res_o holds its result; a closing byte then waits in the input
// register, and byte_i drops ready once that register cannot advance.
// Reset clears both register stages and the decode state, so the next byte
// starts a new string.
`default_nettype none

module utf8_stream_validator_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  u8v_byte_if.sink   byte_i,
  u8v_res_if.source  res_o
);

  logic                 s1_valid_q;
  logic [7:0]           s1_byte_q;
  logic                 s1_last_q;
  u8v_pkg::u8v_state_t  state_q, state_d;
  u8v_pkg::u8v_result_t res_d, res_q;
  logic                 out_valid_q;
  logic                 out_free;
  logic                 s1_adv;

  assign out_free     = !out_valid_q || res_o.ready;
  assign s1_adv       = s1_valid_q && (!s1_last_q || out_free);
  assign byte_i.ready = !s1_valid_q || s1_adv;

  u8v_step u_step (
    .state_i     (state_q),
    .data_byte_i (s1_byte_q),
    .last_byte_i (s1_last_q),
    .state_o     (state_d),
    .result_o    (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      state_q     <= u8v_pkg::STATE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (byte_i.ready) begin
        s1_valid_q <= byte_i.valid;
      end
      if (s1_adv) begin
        state_q <= state_d;
      end
      // load a result on a closing byte, drop it once taken
      if (s1_adv && s1_last_q) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.ready && byte_i.valid) begin
      s1_byte_q <= byte_i.data_byte;
      s1_last_q <= byte_i.last_byte;
    end
    if (s1_adv && s1_last_q) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.valid_res  = res_q.valid_res;
  assign res_o.error_kind = res_q.error_kind;

endmodule

`default_nettype wire
